// ===== design/point_sprite_rasterizer_macros.svh =====
// assertion helpers shared by the rasterizer rtl
`ifndef POINT_SPRITE_RASTERIZER_MACROS_SVH
`define POINT_SPRITE_RASTERIZER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSR_ASSERT_NOW(label, ck, rst_n, pre, post) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("psr: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PSR_ASSERT_NEXT(label, ck, rst_n, pre, post) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("psr: next-cycle check failed");

`endif

// ===== design/psr_pkg.sv =====
`default_nettype none

package psr_pkg;

	// port field width and internal coordinate width (field plus add headroom)
	localparam int FIELD_W    = 16;
	localparam int CALC_W     = 18;
	localparam int SIZE_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	// one pixel in q12.4 units
	localparam int PIX_STEP   = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_SIZE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MIN_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MAX_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MIN_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MAX_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ENABLE = 3'd5;

	typedef struct packed {
		logic signed [FIELD_W-1:0] vert_x;
		logic signed [FIELD_W-1:0] vert_y;
		logic [FIELD_W-1:0]        vertex_tag;
	} vertex_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] frag_x;
		logic signed [FIELD_W-1:0] frag_y;
		logic [FIELD_W-1:0]        frag_tag;
		logic                      last_fragment;
	} fragment_t;

	function automatic logic signed [CALC_W-1:0] widen(input logic signed [FIELD_W-1:0] v);
		return CALC_W'(v);
	endfunction

endpackage

`default_nettype wire

// ===== design/psr_intf.sv =====
`default_nettype none

interface psr_vertex_if;
	import psr_pkg::*;
	logic    valid;
	logic    ready;
	vertex_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface psr_fragment_if;
	import psr_pkg::*;
	logic      valid;
	logic      ready;
	fragment_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/point_sprite_rasterizer.sv =====
// size 1 point: the vertex is held as the pending word and goes to the output register
//   from flush once the output is free; larger points pass setup, clip and row to reach the
//   first tested position, a word leaves one kept position later; vertices are taken only in
//   idle, one at a time; the walk tests one position a cycle unless a kept one waits for the output
// reset: arst_n clears the sequencer, the pending and output words and loads the register
//   defaults (size 1, clip 0..32767 on both axes, smooth off); no clearing pass
`default_nettype none

module point_sprite_rasterizer #(
	parameter int MAX_POINT_SIZE = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	psr_vertex_if.sink                        vertex,
	psr_fragment_if.source                    fragment,
	input  logic                              cfg_we,
	input  logic [psr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [psr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import psr_pkg::*;

	`include "point_sprite_rasterizer_macros.svh"

	// largest half side in q12.4 units, offset and square widths follow from it
	localparam int HALF_MAX = MAX_POINT_SIZE * 8;
	localparam int DW       = $clog2(HALF_MAX) + 1;
	localparam int SQW      = 2 * DW;

	// sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a vertex
	localparam logic [2:0] ST_SETUP = 3'd1;  // raw square bounds, radius squared
	localparam logic [2:0] ST_CLIP  = 3'd2;  // clamp or reject against the clip box
	localparam logic [2:0] ST_ROW   = 3'd3;  // row test, dy squared
	localparam logic [2:0] ST_COL   = 3'd4;  // one position per cycle unless a kept one waits for the output
	localparam logic [2:0] ST_FLUSH = 3'd5;  // hand off the held word as the last one

	// configuration registers
	logic [SIZE_W-1:0]         sprite_size_q;
	logic signed [FIELD_W-1:0] clip_min_x_q;
	logic signed [FIELD_W-1:0] clip_max_x_q;
	logic signed [FIELD_W-1:0] clip_min_y_q;
	logic signed [FIELD_W-1:0] clip_max_y_q;
	logic                      smooth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_size_q <= SIZE_W'(1);
			clip_min_x_q  <= '0;
			clip_max_x_q  <= 16'sh7FFF;
			clip_min_y_q  <= '0;
			clip_max_y_q  <= 16'sh7FFF;
			smooth_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPRITE_SIZE:   sprite_size_q <= cfg_data[SIZE_W-1:0];
				REG_CLIP_MIN_X:    clip_min_x_q  <= cfg_data;
				REG_CLIP_MAX_X:    clip_max_x_q  <= cfg_data;
				REG_CLIP_MIN_Y:    clip_min_y_q  <= cfg_data;
				REG_CLIP_MAX_Y:    clip_max_y_q  <= cfg_data;
				REG_SMOOTH_ENABLE: smooth_q      <= cfg_data[0];
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	// control and working state
	logic [2:0]               state_q, state_d;
	logic                     pend_valid_q;
	logic                     out_valid_q;
	logic [SIZE_W-1:0]        size_q;
	logic signed [CALC_W-1:0] vx_q, vy_q;
	logic [FIELD_W-1:0]       tag_q;
	logic signed [CALC_W-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
	logic signed [CALC_W-1:0] x_q, y_q;
	logic signed [DW-1:0]     dx_q, dy_q;
	logic [SQW-1:0]           r2_q, dy2_q;
	logic [FIELD_W-1:0]       pend_x_q, pend_y_q;
	fragment_t                out_data_q;

	// size 0 behaves as 1, oversize saturates
	logic [SIZE_W-1:0] size_eff;
	logic              size_one;

	always_comb begin
		if (sprite_size_q == '0)
			size_eff = SIZE_W'(1);
		else if (sprite_size_q > SIZE_W'(MAX_POINT_SIZE))
			size_eff = SIZE_W'(MAX_POINT_SIZE);
		else
			size_eff = sprite_size_q;
	end

	assign size_one = (size_eff == SIZE_W'(1));

	// half side = size * 8 units
	logic signed [CALC_W-1:0] half_c;
	assign half_c = CALC_W'({size_q, 3'b000});

	// clip test: each bound clamps, or else may reject; low x rejects on equality with max_x
	logic signed [CALC_W-1:0] cmin_x, cmax_x, cmin_y, cmax_y;
	logic                     lo_x_under, hi_x_over, lo_y_under, hi_y_over;
	logic                     reject_c;
	logic signed [CALC_W-1:0] lo_x_c, hi_x_c, lo_y_c, hi_y_c;

	assign cmin_x = widen(clip_min_x_q);
	assign cmax_x = widen(clip_max_x_q);
	assign cmin_y = widen(clip_min_y_q);
	assign cmax_y = widen(clip_max_y_q);

	assign lo_y_under = (lo_y_q < cmin_y);
	assign hi_y_over  = (hi_y_q > cmax_y);
	assign lo_x_under = (lo_x_q < cmin_x);
	assign hi_x_over  = (hi_x_q > cmax_x);

	assign reject_c = (!lo_y_under && (lo_y_q > cmax_y))
	               || (!hi_y_over && (hi_y_q < cmin_y))
	               || (!lo_x_under && (lo_x_q >= cmax_x))
	               || (!hi_x_over && (hi_x_q < cmin_x));

	assign lo_y_c = lo_y_under ? cmin_y : lo_y_q;
	assign hi_y_c = hi_y_over ? cmax_y : hi_y_q;
	assign lo_x_c = lo_x_under ? cmin_x : lo_x_q;
	assign hi_x_c = hi_x_over ? cmax_x : hi_x_q;

	// shared squarer: radius in setup, |dy| at row start, |dx| per position
	logic [DW-1:0]  sq_op;
	logic [SQW-1:0] sq_res;

	always_comb begin
		unique case (state_q)
			ST_SETUP: sq_op = DW'({size_q, 3'b000});
			ST_ROW:   sq_op = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
			default:  sq_op = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
		endcase
	end

	assign sq_res = SQW'(sq_op) * SQW'(sq_op);

	// round mask: with smooth on, keep strictly inside the circle; smooth off keeps all
	logic [SQW:0] dist2;
	logic         keep;
	assign dist2 = {1'b0, sq_res} + {1'b0, dy2_q};
	assign keep  = !smooth_q || (dist2 < {1'b0, r2_q});

	logic row_live, col_live, out_free;
	assign row_live = (y_q < hi_y_q);
	assign col_live = (x_q < hi_x_q);
	assign out_free = !out_valid_q || fragment.ready;

	// sequencer; a kept position is held until the next kept one or the flush so the last word can be flagged
	logic push, push_last, pend_load, pend_clr;
	logic start_row, step_x, step_y;

	always_comb begin
		state_d   = state_q;
		push      = 1'b0;
		push_last = 1'b0;
		pend_load = 1'b0;
		pend_clr  = 1'b0;
		start_row = 1'b0;
		step_x    = 1'b0;
		step_y    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (vertex.valid) begin
					state_d   = size_one ? ST_FLUSH : ST_SETUP;
					pend_load = size_one;
				end
			end
			ST_SETUP: state_d = ST_CLIP;
			ST_CLIP:  state_d = reject_c ? ST_IDLE : ST_ROW;
			ST_ROW: begin
				if (row_live) begin
					start_row = 1'b1;
					state_d   = ST_COL;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_COL: begin
				if (!col_live) begin
					step_y  = 1'b1;
					state_d = ST_ROW;
				end else if (!keep) begin
					step_x = 1'b1;
				end else if (!pend_valid_q || out_free) begin
					push      = pend_valid_q;
					pend_load = 1'b1;
					step_x    = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					pend_clr  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pend_load)
				pend_valid_q <= 1'b1;
			else if (pend_clr)
				pend_valid_q <= 1'b0;
			if (push)
				out_valid_q <= 1'b1;
			else if (fragment.ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && vertex.valid) begin
			vx_q   <= widen(vertex.data.vert_x);
			vy_q   <= widen(vertex.data.vert_y);
			tag_q  <= vertex.data.vertex_tag;
			size_q <= size_eff;
		end
		if (state_q == ST_SETUP) begin
			lo_y_q <= vy_q - half_c;
			hi_y_q <= vy_q + half_c;
			lo_x_q <= vx_q - half_c;
			hi_x_q <= vx_q + half_c;
			r2_q   <= sq_res;
		end
		if (state_q == ST_CLIP) begin
			lo_x_q <= lo_x_c;
			hi_x_q <= hi_x_c;
			hi_y_q <= hi_y_c;
			y_q    <= lo_y_c;
			dy_q   <= DW'(lo_y_c - vy_q);
		end
		if (start_row) begin
			dy2_q <= sq_res;
			x_q   <= lo_x_q;
			dx_q  <= DW'(lo_x_q - vx_q);
		end
		if (step_x) begin
			x_q  <= x_q + CALC_W'(PIX_STEP);
			dx_q <= dx_q + DW'(PIX_STEP);
		end
		if (step_y) begin
			y_q  <= y_q + CALC_W'(PIX_STEP);
			dy_q <= dy_q + DW'(PIX_STEP);
		end
		// held word: the vertex itself for size 1, else the walk position
		if (pend_load) begin
			if (state_q == ST_IDLE) begin
				pend_x_q <= vertex.data.vert_x;
				pend_y_q <= vertex.data.vert_y;
			end else begin
				pend_x_q <= x_q[FIELD_W-1:0];
				pend_y_q <= y_q[FIELD_W-1:0];
			end
		end
		if (push) begin
			out_data_q.frag_x        <= pend_x_q;
			out_data_q.frag_y        <= pend_y_q;
			out_data_q.frag_tag      <= tag_q;
			out_data_q.last_fragment <= push_last;
		end
	end

	assign vertex.ready   = (state_q == ST_IDLE);
	assign fragment.valid = out_valid_q;
	assign fragment.data  = out_data_q;

	// a held word never outlives its vertex
	`PSR_ASSERT_NOW(a_pend_not_idle, clk, arst_n, pend_valid_q, state_q != ST_IDLE)
	// the final word ends the vertex
	`PSR_ASSERT_NEXT(a_last_to_idle, clk, arst_n, push && push_last, state_q == ST_IDLE)
	// x offset tracks the walk position
	`PSR_ASSERT_NOW(a_dx_track, clk, arst_n, state_q == ST_COL && col_live,
		dx_q == DW'(x_q - vx_q))
	// a stalled output word is never overwritten
	`PSR_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid_q && !fragment.ready, !push)

endmodule

`default_nettype wire
